// ----- hw/rtl/rcnb_pkg.sv -----
// Package for the RCNB word encoder: digit radices, reciprocal constants
// and the four symbol tables. No dependencies.
package rcnb_pkg;

  localparam int unsigned WordW = 16;
  localparam int unsigned ValW  = 15;
  localparam int unsigned CharW = 10;
  localparam int unsigned DigW  = 4;

  // Radices of the mixed-radix split of v.
  localparam logic [15:0] ModR = 16'd2250;
  localparam logic [15:0] ModC = 16'd150;
  localparam logic [7:0]  ModN = 8'd10;

  // Reciprocals: RecipR underestimates by at most one, RecipC and RecipN are
  // exact over the remainder ranges that reach them.
  localparam logic [4:0]  RecipR = 5'd29;   // 2^16 / 2250
  localparam logic [8:0]  RecipC = 9'd437;  // 2^16 / 150
  localparam logic [7:0]  RecipN = 8'd205;  // 2^11 / 10

  typedef logic [CharW-1:0] char_t;
  typedef logic [DigW-1:0]  digit_t;

  function automatic char_t sym_r(input digit_t d);
    char_t c;
    case (d)
      4'd0:    c = 10'd114;
      4'd1:    c = 10'd82;
      4'd2:    c = 10'd340;
      4'd3:    c = 10'd341;
      4'd4:    c = 10'd342;
      4'd5:    c = 10'd343;
      4'd6:    c = 10'd344;
      4'd7:    c = 10'd345;
      4'd8:    c = 10'd422;
      4'd9:    c = 10'd528;
      4'd10:   c = 10'd529;
      4'd11:   c = 10'd530;
      4'd12:   c = 10'd531;
      4'd13:   c = 10'd588;
      4'd14:   c = 10'd589;
      default: c = 10'd0;
    endcase
    return c;
  endfunction

  function automatic char_t sym_c(input digit_t d);
    char_t c;
    case (d)
      4'd0:    c = 10'd99;
      4'd1:    c = 10'd67;
      4'd2:    c = 10'd262;
      4'd3:    c = 10'd263;
      4'd4:    c = 10'd264;
      4'd5:    c = 10'd265;
      4'd6:    c = 10'd266;
      4'd7:    c = 10'd267;
      4'd8:    c = 10'd268;
      4'd9:    c = 10'd269;
      4'd10:   c = 10'd391;
      4'd11:   c = 10'd392;
      4'd12:   c = 10'd199;
      4'd13:   c = 10'd571;
      4'd14:   c = 10'd572;
      default: c = 10'd0;
    endcase
    return c;
  endfunction

  function automatic char_t sym_n(input digit_t d);
    char_t c;
    case (d)
      4'd0:    c = 10'd110;
      4'd1:    c = 10'd78;
      4'd2:    c = 10'd323;
      4'd3:    c = 10'd324;
      4'd4:    c = 10'd325;
      4'd5:    c = 10'd326;
      4'd6:    c = 10'd327;
      4'd7:    c = 10'd328;
      4'd8:    c = 10'd413;
      4'd9:    c = 10'd414;
      4'd10:   c = 10'd209;
      4'd11:   c = 10'd504;
      4'd12:   c = 10'd505;
      4'd13:   c = 10'd544;
      4'd14:   c = 10'd565;
      default: c = 10'd0;
    endcase
    return c;
  endfunction

  function automatic char_t sym_b(input digit_t d);
    char_t c;
    case (d)
      4'd0:    c = 10'd98;
      4'd1:    c = 10'd66;
      4'd2:    c = 10'd384;
      4'd3:    c = 10'd385;
      4'd4:    c = 10'd387;
      4'd5:    c = 10'd388;
      4'd6:    c = 10'd389;
      4'd7:    c = 10'd223;
      4'd8:    c = 10'd222;
      4'd9:    c = 10'd254;
      default: c = 10'd0;
    endcase
    return c;
  endfunction

endpackage

// ----- hw/rtl/rcnb_in_if.sv -----
// Input channel of the RCNB word encoder: one 16-bit word and a last flag.
// Uses rcnb_pkg for the word width.
interface rcnb_in_if;
  logic                           valid;
  logic                           ready;
  logic [rcnb_pkg::WordW-1:0]     word;
  logic                           last;

  modport source (output valid, output word, output last, input ready);
  modport sink   (input valid, input word, input last, output ready);
endinterface

// ----- hw/rtl/rcnb_out_if.sv -----
// Output channel of the RCNB word encoder: one quad of code points and the
// last flag. Uses rcnb_pkg for the character type.
interface rcnb_out_if;
  logic            valid;
  logic            ready;
  rcnb_pkg::char_t char0;
  rcnb_pkg::char_t char1;
  rcnb_pkg::char_t char2;
  rcnb_pkg::char_t char3;
  logic            last_out;

  modport source (output valid, output char0, output char1, output char2,
                  output char3, output last_out, input ready);
  modport sink   (input valid, input char0, input char1, input char2,
                  input char3, input last_out, output ready);
endinterface

// ----- hw/rtl/rcnb_word_encoder_top.sv -----
// RCNB word encoder: six-stage pipeline that turns each 16-bit word into a
// quad of code points. Depends on rcnb_pkg, rcnb_in_if and rcnb_out_if.
//
// Usage:
//   words carries one request per 16-bit word (first byte in the high half)
//   plus a last flag. quads carries one request per word: four 10-bit code
//   points in r,c,n,b order, or n,b,r,c when bit 15 of the word is set, and
//   the last flag copied through.
//   Throughput is one word per cycle while quads.ready stays high. The six
//   register stages, in order, are: reciprocal estimate of the top digit,
//   correction of that digit and its remainder, second digit, second
//   remainder, the last two digits, and the table lookup with order swap
//   into the output register.
//   Each stage holds its item while the stage behind it is full and stalled,
//   so when the receiver drops ready the pipeline fills up and then
//   words.ready falls; no request is lost or repeated. Bubbles close up.
//   Reset (synchronous, active high) empties every stage; there is no other
//   state.
module rcnb_word_encoder_top (
  input  logic        clk,
  input  logic        rst,
  rcnb_in_if.sink     words,
  rcnb_out_if.source  quads
);

  localparam int unsigned NumStages = 6;

  logic [NumStages-1:0] val;
  logic [NumStages-1:0] adv;

  // A stage may load when it is empty or its content moves on this cycle.
  always_comb begin
    adv[NumStages-1] = !val[NumStages-1] || quads.ready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      adv[k] = !val[k] || adv[k+1];
    end
  end

  assign words.ready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      val <= '0;
    end else begin
      if (adv[0]) begin
        val[0] <= words.valid;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (adv[k]) begin
          val[k] <= val[k-1];
        end
      end
    end
  end

  // Stage 1: estimate of v / 2250.
  logic [rcnb_pkg::ValW-1:0] s1_v;
  rcnb_pkg::digit_t          s1_est;
  logic                      s1_swap;
  logic                      s1_last;
  logic [19:0]               s1_prod;

  assign s1_prod = 20'(words.word[rcnb_pkg::ValW-1:0]) * 20'(rcnb_pkg::RecipR);

  always_ff @(posedge clk) begin
    if (adv[0] && words.valid) begin
      s1_v    <= words.word[rcnb_pkg::ValW-1:0];
      s1_est  <= s1_prod[19:16];
      s1_swap <= words.word[rcnb_pkg::WordW-1];
      s1_last <= words.last;
    end
  end

  // Stage 2: the estimate is at most one low, so one compare fixes it.
  logic [15:0]      s2_rem0;
  logic [15:0]      s2_rem_c;
  rcnb_pkg::digit_t s2_dr;
  logic [11:0]      s2_rem;
  logic             s2_swap;
  logic             s2_last;

  always_comb begin
    s2_rem0  = 16'(s1_v) - (16'(s1_est) * rcnb_pkg::ModR);
    s2_rem_c = s2_rem0 - rcnb_pkg::ModR;
  end

  always_ff @(posedge clk) begin
    if (adv[1] && val[0]) begin
      if (s2_rem0 >= rcnb_pkg::ModR) begin
        s2_dr  <= s1_est + 4'd1;
        s2_rem <= s2_rem_c[11:0];
      end else begin
        s2_dr  <= s1_est;
        s2_rem <= s2_rem0[11:0];
      end
      s2_swap <= s1_swap;
      s2_last <= s1_last;
    end
  end

  // Stage 3: second digit, remainder / 150.
  logic [20:0]      s3_prod;
  rcnb_pkg::digit_t s3_dr;
  rcnb_pkg::digit_t s3_dc;
  logic [11:0]      s3_rem;
  logic             s3_swap;
  logic             s3_last;

  assign s3_prod = 21'(s2_rem) * 21'(rcnb_pkg::RecipC);

  always_ff @(posedge clk) begin
    if (adv[2] && val[1]) begin
      s3_dr   <= s2_dr;
      s3_dc   <= s3_prod[19:16];
      s3_rem  <= s2_rem;
      s3_swap <= s2_swap;
      s3_last <= s2_last;
    end
  end

  // Stage 4: remainder below 150.
  logic [11:0]      s4_rem_full;
  rcnb_pkg::digit_t s4_dr;
  rcnb_pkg::digit_t s4_dc;
  logic [7:0]       s4_rem;
  logic             s4_swap;
  logic             s4_last;

  assign s4_rem_full = s3_rem - (12'(s3_dc) * 12'(rcnb_pkg::ModC));

  always_ff @(posedge clk) begin
    if (adv[3] && val[2]) begin
      s4_dr   <= s3_dr;
      s4_dc   <= s3_dc;
      s4_rem  <= s4_rem_full[7:0];
      s4_swap <= s3_swap;
      s4_last <= s3_last;
    end
  end

  // Stage 5: last two digits, remainder / 10 and remainder % 10.
  logic [15:0]      s5_prod;
  rcnb_pkg::digit_t s5_dn_c;
  logic [7:0]       s5_db_full;
  rcnb_pkg::digit_t s5_dr;
  rcnb_pkg::digit_t s5_dc;
  rcnb_pkg::digit_t s5_dn;
  rcnb_pkg::digit_t s5_db;
  logic             s5_swap;
  logic             s5_last;

  always_comb begin
    s5_prod    = 16'(s4_rem) * 16'(rcnb_pkg::RecipN);
    s5_dn_c    = s5_prod[14:11];
    s5_db_full = s4_rem - (8'(s5_dn_c) * rcnb_pkg::ModN);
  end

  always_ff @(posedge clk) begin
    if (adv[4] && val[3]) begin
      s5_dr   <= s4_dr;
      s5_dc   <= s4_dc;
      s5_dn   <= s5_dn_c;
      s5_db   <= s5_db_full[3:0];
      s5_swap <= s4_swap;
      s5_last <= s4_last;
    end
  end

  // Stage 6: symbol lookup and order swap into the output register.
  rcnb_pkg::char_t cr;
  rcnb_pkg::char_t cc;
  rcnb_pkg::char_t cn;
  rcnb_pkg::char_t cb;

  always_comb begin
    cr = rcnb_pkg::sym_r(s5_dr);
    cc = rcnb_pkg::sym_c(s5_dc);
    cn = rcnb_pkg::sym_n(s5_dn);
    cb = rcnb_pkg::sym_b(s5_db);
  end

  always_ff @(posedge clk) begin
    if (adv[5] && val[4]) begin
      if (s5_swap) begin
        quads.char0 <= cn;
        quads.char1 <= cb;
        quads.char2 <= cr;
        quads.char3 <= cc;
      end else begin
        quads.char0 <= cr;
        quads.char1 <= cc;
        quads.char2 <= cn;
        quads.char3 <= cb;
      end
      quads.last_out <= s5_last;
    end
  end

  assign quads.valid = val[NumStages-1];

endmodule

// ----- hw/rtl/rcnb_checker.sv -----
// Port-level checker for the RCNB word encoder and its bind to the top level.
// Depends on rcnb_pkg and rcnb_word_encoder_top.
module rcnb_checker (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input rcnb_pkg::char_t char0,
  input rcnb_pkg::char_t char1,
  input rcnb_pkg::char_t char2,
  input rcnb_pkg::char_t char3,
  input logic            last_out
);

  logic [2:0] pending;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Requests accepted whose quads have not yet been delivered.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (in_acc && !out_acc) begin
      pending <= pending + 3'd1;
    end else if (out_acc && !in_acc) begin
      pending <= pending - 3'd1;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(char0) && $stable(char1)
      && $stable(char2) && $stable(char3) && $stable(last_out))
    else $error("stalled quad changed or dropped");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 3'd0)
    else $error("quad offered without a pending word");

  // With every stage full, a new request can only enter while one leaves.
  a_depth: assert property (@(posedge clk) disable iff (rst)
    pending <= 3'd6 && (pending != 3'd6 || !in_ready || out_ready))
    else $error("more words in flight than pipeline stages");

  a_symbols: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> char0 != 10'd0 && char1 != 10'd0 && char2 != 10'd0
      && char3 != 10'd0)
    else $error("quad holds a code point outside the symbol tables");

endmodule

bind rcnb_word_encoder_top rcnb_checker u_rcnb_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (words.valid),
  .in_ready  (words.ready),
  .out_valid (quads.valid),
  .out_ready (quads.ready),
  .char0     (quads.char0),
  .char1     (quads.char1),
  .char2     (quads.char2),
  .char3     (quads.char3),
  .last_out  (quads.last_out)
);

// ----- dv/rcnb_word_encoder_top_test.sv -----
// Testbench for rcnb_word_encoder_top: drives words with random gaps, predicts
// each quad of code points and checks the results in order.
// Depends on rcnb_pkg, rcnb_in_if, rcnb_out_if and the encoder RTL.
module rcnb_word_encoder_top_test;

  typedef logic [rcnb_pkg::WordW-1:0] word_t;

  typedef struct packed {
    rcnb_pkg::char_t char0;
    rcnb_pkg::char_t char1;
    rcnb_pkg::char_t char2;
    rcnb_pkg::char_t char3;
    logic            last_out;
  } quad_t;

  localparam int unsigned StallLimit = 5000;
  localparam int unsigned DrainCycles = 20;

  localparam rcnb_pkg::char_t RTab [15] = '{114, 82, 340, 341, 342, 343, 344,
                                            345, 422, 528, 529, 530, 531, 588,
                                            589};
  localparam rcnb_pkg::char_t CTab [15] = '{99, 67, 262, 263, 264, 265, 266,
                                            267, 268, 269, 391, 392, 199, 571,
                                            572};
  localparam rcnb_pkg::char_t NTab [15] = '{110, 78, 323, 324, 325, 326, 327,
                                            328, 413, 414, 209, 504, 505, 544,
                                            565};
  localparam rcnb_pkg::char_t BTab [10] = '{98, 66, 384, 385, 387, 388, 389,
                                            223, 222, 254};

  logic clk;
  logic rst;

  rcnb_in_if  words ();
  rcnb_out_if quads ();

  rcnb_word_encoder_top dut (
    .clk   (clk),
    .rst   (rst),
    .words (words),
    .quads (quads)
  );

  quad_t       pending_quads [$];
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned fail_count;
  int unsigned mismatch_count;
  int unsigned quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic quad_t encode_word(input word_t w, input logic l);
    quad_t q;
    int unsigned v;
    rcnb_pkg::char_t cr;
    rcnb_pkg::char_t cc;
    rcnb_pkg::char_t cn;
    rcnb_pkg::char_t cb;
    v  = w[rcnb_pkg::ValW-1:0];
    cr = RTab[v / 2250];
    cc = CTab[(v % 2250) / 150];
    cn = NTab[(v % 150) / 10];
    cb = BTab[v % 10];
    if (w[rcnb_pkg::WordW-1]) begin
      q.char0 = cn;
      q.char1 = cb;
      q.char2 = cr;
      q.char3 = cc;
    end else begin
      q.char0 = cr;
      q.char1 = cc;
      q.char2 = cn;
      q.char3 = cb;
    end
    q.last_out = l;
    return q;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_word(input word_t w, input logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      words.valid = 1'b0;
      @(negedge clk);
    end
    words.valid = 1'b1;
    words.word  = w;
    words.last  = l;
    @(posedge clk);
    while (!words.ready) @(posedge clk);
    pending_quads.push_back(encode_word(w, l));
    @(negedge clk);
  endtask

  task automatic wait_for_drain();
    words.valid = 1'b0;
    while (pending_quads.size() != 0) @(negedge clk);
  endtask

  // Builds v from chosen digits so that every table entry gets hit often.
  function automatic word_t digit_word();
    int unsigned v;
    v = 32768;
    while (v > 32767) begin
      v = $urandom_range(14) * 2250 + $urandom_range(14) * 150 +
          $urandom_range(14) * 10 + $urandom_range(9);
    end
    return {1'($urandom_range(1)), 15'(v)};
  endfunction

  task automatic test_directed_words();
    word_t list [$];
    list = '{16'h0000, 16'h7fff, 16'h8000, 16'hffff, 16'h5555, 16'haaaa,
             16'd9, 16'd10, 16'd149, 16'd150, 16'd2249, 16'd2250,
             16'd31499, 16'd31500, 16'd32767 - 16'd8, 16'h8000 | 16'd2249,
             16'h8000 | 16'd31500, 16'h8000 | 16'd149};
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    foreach (list[i]) send_word(list[i], 1'(i % 2));
    wait_for_drain();
  endtask

  task automatic test_random_words(input int unsigned n, input int unsigned idle,
                                   input int unsigned stall);
    word_t w;
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    repeat (n) begin
      if ($urandom_range(1) == 0) w = 16'($urandom);
      else w = digit_word();
      send_word(w, 1'($urandom_range(7) == 0));
    end
  endtask

  // The sender holds off until the pipeline has fully emptied, then resumes.
  task automatic test_drain_pause();
    send_idle_pct  = 0;
    recv_stall_pct = 61;
    repeat (3) begin
      repeat (12) send_word(16'($urandom), 1'($urandom_range(1)));
      wait_for_drain();
    end
  endtask

  always @(negedge clk) begin
    if (!rst) quads.ready = ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    quad_t got;
    quad_t want;
    if (!rst && quads.valid && quads.ready) begin
      got = '{quads.char0, quads.char1, quads.char2, quads.char3, quads.last_out};
      if (pending_quads.size() == 0) begin
        fail_count++;
        if (mismatch_count < 10)
          $display("unexpected quad %0d %0d %0d %0d last %0b", got.char0,
                   got.char1, got.char2, got.char3, got.last_out);
        mismatch_count++;
      end else begin
        want = pending_quads.pop_front();
        if (got !== want) begin
          fail_count++;
          if (mismatch_count < 10)
            $display("quad mismatch: expected %0d %0d %0d %0d last %0b, got %0d %0d %0d %0d last %0b",
                     want.char0, want.char1, want.char2, want.char3, want.last_out,
                     got.char0, got.char1, got.char2, got.char3, got.last_out);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((words.valid && words.ready) || (quads.valid && quads.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles == StallLimit) begin
        $display("rcnb_word_encoder_top verification failed");
        $finish;
      end
    end
  end

  initial begin
    fail_count     = 0;
    mismatch_count = 0;
    quiet_cycles   = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst            = 1'b1;
    words.valid    = 1'b0;
    words.word     = '0;
    words.last     = 1'b0;
    quads.ready    = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    test_directed_words();
    test_random_words(350, 0, 0);
    test_random_words(350, 61, 0);
    test_drain_pause();
    test_random_words(350, 0, 61);
    test_random_words(350, 10, 10);
    test_random_words(50, 0, 0);

    wait_for_drain();
    repeat (DrainCycles) @(posedge clk);
    if (pending_quads.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("rcnb_word_encoder_top verification clean");
    end else begin
      $display("rcnb_word_encoder_top verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/rcnb_pkg.sv
hw/rtl/rcnb_in_if.sv
hw/rtl/rcnb_out_if.sv
hw/rtl/rcnb_word_encoder_top.sv
hw/rtl/rcnb_checker.sv
dv/rcnb_word_encoder_top_test.sv
